>>> hdl/huffman_tree_bit_decoder_macros.svh
// Assertion macros for the Huffman tree bit decoder.
// Used by the decoder top level; no other dependencies.
`ifndef HUFFMAN_TREE_BIT_DECODER_MACROS_SVH
`define HUFFMAN_TREE_BIT_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HTBD_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/htbd_pkg.sv
// Shared types and constants for the Huffman tree bit decoder.
// No dependencies; imported by the node store and the top level.
`timescale 1ns / 1ps

package htbd_pkg;

  localparam int NODE_W         = 9;
  localparam int SYM_W          = 8;
  localparam int BYTE_W         = 8;
  localparam int CNT_W          = 32;
  localparam int BIT_CNT_W      = 3;
  localparam int TREE_NODES_DEF = 512;

  typedef enum logic [1:0] {
    OP_WRITE_NODE = 2'd0,
    OP_DECODE     = 2'd1,
    OP_START      = 2'd2
  } op_e;

  typedef struct packed {
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic              leaf;
    logic [SYM_W-1:0]  symbol;
  } node_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
  } store_rd_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    node_t             node;
  } store_wr_t;

endpackage

>>> hdl/huffman_tree_bit_decoder.sv
// Huffman tree bit decoder top level: request sequencer, result staging.
// Uses htbd_pkg, htbd_node_store and huffman_tree_bit_decoder_macros.svh.
//
// Use: load the code tree with write-node requests (node 0 is the root), set
// the symbol count on cfg_we_i/cfg_wdata_i, send a start request, then send
// data bytes. Each byte is walked MSB first; every leaf reached gives one
// result (symbol, last-of-byte flag, frame-done flag), up to eight per byte.
// Both channels use valid/stall; a request is taken when valid is high and
// stall is low.
// Write-node and start requests never raise the input stall. A data byte is
// accepted, then per bit the node store is read at the current node and,
// unless it is a leaf, once more at the child. The byte ends with a flush of
// its last symbol if it gives any; the walk stops early when the frame ends
// partway. The node store has a single read port.
// The last symbol of a byte is held until the byte ends so its flag is known.
// Once the remaining count reaches zero, bits are ignored.
// Reset clears the walk to the root and the count and config to zero; the
// tree store is not cleared. A stalled result waits in the output register;
// further results wait behind it and the byte walk stalls meanwhile.
`timescale 1ns / 1ps
`include "huffman_tree_bit_decoder_macros.svh"

module huffman_tree_bit_decoder import htbd_pkg::*; #(
  parameter int TREE_NODES = TREE_NODES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CNT_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  input  logic [NODE_W-1:0]   node_index_i,
  input  logic [NODE_W-1:0]   left_child_i,
  input  logic [NODE_W-1:0]   right_child_i,
  input  logic                is_leaf_i,
  input  logic [SYM_W-1:0]    leaf_symbol_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SYM_W-1:0]    symbol_out_o,
  output logic                last_of_run_o,
  output logic                frame_done_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HERE,
    S_NEXT,
    S_FLUSH
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       cfg_count_q;
  logic [CNT_W-1:0]       rem_q;
  logic [NODE_W-1:0]      pos_q;
  logic [NODE_W-1:0]      next_q;
  logic [BYTE_W-1:0]      byte_q;
  logic [BIT_CNT_W-1:0]   bit_cnt_q;
  logic                   pend_valid_q;
  logic [SYM_W-1:0]       pend_sym_q;
  logic                   pend_done_q;
  logic                   out_valid_q;
  logic [SYM_W-1:0]       out_sym_q;
  logic                   out_last_q;
  logic                   out_done_q;

  store_wr_t              st_wr;
  store_rd_t              st_rd;
  node_t                  node;
  op_e                    op;
  logic                   slot_free;
  logic                   step_go;
  logic                   step_emit;
  logic                   bit_end;
  logic                   finish;
  logic                   out_load;
  logic [NODE_W-1:0]      next_addr;
  logic [NODE_W-1:0]      pos_new;
  logic                   walking;

  htbd_node_store #(
    .TREE_NODES (TREE_NODES)
  ) u_store (
    .clk_i     (clk_i),
    .wr_i      (st_wr),
    .rd_i      (st_rd),
    .rd_node_o (node)
  );

  assign op         = op_e'(op_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign walking    = (state_q == S_HERE) || (state_q == S_NEXT);
  assign next_addr  = byte_q[BYTE_W-1] ? node.right : node.left;

  // emitting while a symbol is pending needs the output register
  assign step_go    = walking && (!node.leaf || !pend_valid_q || slot_free);
  assign step_emit  = step_go && node.leaf;
  assign bit_end    = step_go && ((state_q == S_NEXT) || node.leaf);
  assign pos_new    = (node.leaf || (state_q == S_HERE)) ? '0 : next_q;
  assign finish     = (bit_cnt_q == '1) || (step_emit && (rem_q == CNT_W'(1)));
  assign out_load   = ((state_q == S_FLUSH) && slot_free) || (step_emit && pend_valid_q);

  always_comb begin
    st_wr.en   = (state_q == S_IDLE) && in_valid_i && (op == OP_WRITE_NODE);
    st_wr.addr = node_index_i;
    st_wr.node = '{left: left_child_i, right: right_child_i,
                   leaf: is_leaf_i, symbol: leaf_symbol_i};
    st_rd.en   = 1'b0;
    st_rd.addr = pos_q;
    priority if ((state_q == S_IDLE) && in_valid_i && (op == OP_DECODE) &&
                 (rem_q != '0)) begin
      st_rd.en   = 1'b1;
      st_rd.addr = pos_q;
    end else if ((state_q == S_HERE) && step_go && !node.leaf) begin
      st_rd.en   = 1'b1;
      st_rd.addr = next_addr;
    end else if (bit_end && !finish) begin
      st_rd.en   = 1'b1;
      st_rd.addr = pos_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cfg_count_q  <= '0;
      rem_q        <= '0;
      pos_q        <= '0;
      next_q       <= '0;
      byte_q       <= '0;
      bit_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      pend_sym_q   <= '0;
      pend_done_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_sym_q    <= '0;
      out_last_q   <= 1'b0;
      out_done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_count_q <= cfg_wdata_i;
      end
      out_valid_q <= out_load || (out_valid_q && out_stall_i);

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (op)
              OP_START: begin
                rem_q <= cfg_count_q;
                pos_q <= '0;
              end
              OP_DECODE: begin
                if (rem_q != '0) begin
                  byte_q    <= data_byte_i;
                  bit_cnt_q <= '0;
                  state_q   <= S_HERE;
                end
              end
              default: ;
            endcase
          end
        end
        S_HERE: begin
          if (step_go && !node.leaf) begin
            next_q  <= next_addr;
            state_q <= S_NEXT;
          end
        end
        S_NEXT: ;
        S_FLUSH: begin
          if (slot_free) begin
            out_sym_q    <= pend_sym_q;
            out_last_q   <= 1'b1;
            out_done_q   <= pend_done_q;
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (step_emit) begin
        rem_q        <= rem_q - CNT_W'(1);
        pend_valid_q <= 1'b1;
        pend_sym_q   <= node.symbol;
        pend_done_q  <= (rem_q == CNT_W'(1));
        if (pend_valid_q) begin
          out_sym_q   <= pend_sym_q;
          out_last_q  <= 1'b0;
          out_done_q  <= pend_done_q;
        end
      end

      if (bit_end) begin
        pos_q     <= pos_new;
        byte_q    <= byte_q << 1;
        bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
        if (finish) begin
          state_q <= (pend_valid_q || step_emit) ? S_FLUSH : S_IDLE;
        end else begin
          state_q <= S_HERE;
        end
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_out_o  = out_sym_q;
  assign last_of_run_o = out_last_q;
  assign frame_done_o  = out_done_q;

  `HTBD_ASSERT(a_idle_no_pend, clk_i, rst_ni, !in_stall_o, !pend_valid_q, "pending when idle")
  `HTBD_ASSERT(a_walk_live, clk_i, rst_ni, walking, rem_q != '0, "walk with no count")
  `HTBD_ASSERT(a_done_is_last, clk_i, rst_ni, out_valid_q && out_done_q, out_last_q, "done not last")
  `HTBD_ASSERT_NEXT(a_leaf_to_root, clk_i, rst_ni, step_emit, pos_q == '0, "not at root")

endmodule

>>> hdl/htbd_node_store.sv
// Tree node store: one write and one registered read per cycle.
// Addresses beyond the store read as an all-zero inner node. Uses htbd_pkg.
`timescale 1ns / 1ps

module htbd_node_store import htbd_pkg::*; #(
  parameter int TREE_NODES = TREE_NODES_DEF
) (
  input  logic      clk_i,
  input  store_wr_t wr_i,
  input  store_rd_t rd_i,
  output node_t     rd_node_o
);

  localparam int AW = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;

  node_t            mem_q [TREE_NODES];
  node_t            rd_data_q;
  logic             rd_zero_q;
  logic             wr_in_range;
  logic             rd_in_range;
  logic [AW-1:0]    wr_idx;
  logic [AW-1:0]    rd_idx;

  assign wr_in_range = 32'(wr_i.addr) < 32'(TREE_NODES);
  assign rd_in_range = 32'(rd_i.addr) < 32'(TREE_NODES);
  assign wr_idx      = AW'(wr_i.addr);
  assign rd_idx      = AW'(rd_i.addr);

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_in_range) begin
      mem_q[wr_idx] <= wr_i.node;
    end
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_idx];
      rd_zero_q <= !rd_in_range;
    end
  end

  assign rd_node_o = rd_zero_q ? node_t'('0) : rd_data_q;

endmodule

>>> sim/huffman_tree_bit_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for huffman_tree_bit_decoder: loads code trees, streams
// compressed bytes and compares every decoded symbol with a tree-walk predictor.
// Depends on htbd_pkg and the decoder RTL only.

module huffman_tree_bit_decoder_tb;
  import htbd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [1:0]        op;
    logic [NODE_W-1:0] node_index;
    logic [NODE_W-1:0] left_child;
    logic [NODE_W-1:0] right_child;
    logic              is_leaf;
    logic [SYM_W-1:0]  leaf_symbol;
    logic [BYTE_W-1:0] data_byte;
  } request_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             done;
  } decoded_t;

  class tree_walk_predictor;
    node_t             nodes [TREE_NODES_DEF];
    logic [NODE_W-1:0] walk_at;
    logic [CNT_W-1:0]  frame_count;
    logic [CNT_W-1:0]  left_to_emit;
    decoded_t          symbols_due [$];
    int                mismatches;

    function new();
      foreach (nodes[i]) nodes[i] = '0;
      walk_at      = '0;
      frame_count  = '0;
      left_to_emit = '0;
      mismatches   = 0;
    endfunction

    function void set_frame_count(logic [CNT_W-1:0] v);
      frame_count = v;
    endfunction

    function int pending();
      return symbols_due.size();
    endfunction

    function void walk_byte(logic [BYTE_W-1:0] b);
      node_t             here;
      node_t             nxt;
      logic [NODE_W-1:0] child;
      logic              emit;
      logic [SYM_W-1:0]  sym;
      int                first;
      first = symbols_due.size();
      for (int i = BYTE_W - 1; i >= 0; i--) begin
        if (left_to_emit == 0) break;
        here = nodes[walk_at];
        emit = 1'b0;
        sym  = '0;
        if (here.leaf) begin
          emit    = 1'b1;
          sym     = here.symbol;
          walk_at = '0;
        end else begin
          child = b[i] ? here.right : here.left;
          nxt   = nodes[child];
          if (nxt.leaf) begin
            emit    = 1'b1;
            sym     = nxt.symbol;
            walk_at = '0;
          end else begin
            walk_at = child;
          end
        end
        if (emit) begin
          left_to_emit = left_to_emit - 1;
          symbols_due.push_back('{symbol: sym, last: 1'b0, done: (left_to_emit == 0)});
        end
      end
      if (symbols_due.size() > first) symbols_due[symbols_due.size() - 1].last = 1'b1;
    endfunction

    function void note_request(request_t r);
      case (r.op)
        OP_WRITE_NODE: begin
          nodes[r.node_index] = '{left: r.left_child, right: r.right_child,
                                  leaf: r.is_leaf, symbol: r.leaf_symbol};
        end
        OP_START: begin
          left_to_emit = frame_count;
          walk_at      = '0;
        end
        OP_DECODE: walk_byte(r.data_byte);
        default: ;
      endcase
    endfunction

    function void check_symbol(decoded_t got);
      decoded_t want;
      if (symbols_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected symbol %h last %b done %b",
                   $realtime, got.symbol, got.last, got.done);
      end else begin
        want = symbols_due.pop_front();
        if (got.symbol !== want.symbol || got.last !== want.last || got.done !== want.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: symbol mismatch, expected %h/%b/%b got %h/%b/%b", $realtime,
                     want.symbol, want.last, want.done, got.symbol, got.last, got.done);
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CNT_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        op_i;
  logic [NODE_W-1:0] node_index_i;
  logic [NODE_W-1:0] left_child_i;
  logic [NODE_W-1:0] right_child_i;
  logic              is_leaf_i;
  logic [SYM_W-1:0]  leaf_symbol_i;
  logic [BYTE_W-1:0] data_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [SYM_W-1:0]  symbol_out_o;
  logic              last_of_run_o;
  logic              frame_done_o;

  tree_walk_predictor predictor;
  int in_idle_pct   = 0;
  int out_idle_pct  = 0;
  int hold_left     = 0;
  int requests_sent = 0;
  bit node_taken [TREE_NODES_DEF];

  huffman_tree_bit_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .node_index_i (node_index_i),
    .left_child_i (left_child_i),
    .right_child_i(right_child_i),
    .is_leaf_i    (is_leaf_i),
    .leaf_symbol_i(leaf_symbol_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .symbol_out_o (symbol_out_o),
    .last_of_run_o(last_of_run_o),
    .frame_done_o (frame_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off when requested.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      predictor.check_symbol({symbol_out_o, last_of_run_o, frame_done_o});
  end

  function automatic request_t noise_request();
    request_t    r;
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    r.op          = a[1:0];
    r.node_index  = a[10:2];
    r.left_child  = a[19:11];
    r.right_child = a[28:20];
    r.is_leaf     = a[29];
    r.leaf_symbol = b[7:0];
    r.data_byte   = b[15:8];
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input request_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= r.op;
    node_index_i  <= r.node_index;
    left_child_i  <= r.left_child;
    right_child_i <= r.right_child;
    is_leaf_i     <= r.is_leaf;
    leaf_symbol_i <= r.leaf_symbol;
    data_byte_i   <= r.data_byte;
    do @(posedge clk_i); while (in_stall_o);
    predictor.note_request(r);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic node_write(input logic [NODE_W-1:0] idx, input logic [NODE_W-1:0] lc,
                            input logic [NODE_W-1:0] rc, input logic leaf,
                            input logic [SYM_W-1:0] sym);
    request_t r;
    r = noise_request();
    r.op          = OP_WRITE_NODE;
    r.node_index  = idx;
    r.left_child  = lc;
    r.right_child = rc;
    r.is_leaf     = leaf;
    r.leaf_symbol = sym;
    send_request(r);
  endtask

  task automatic byte_in(input logic [BYTE_W-1:0] b);
    request_t r;
    r = noise_request();
    r.op        = OP_DECODE;
    r.data_byte = b;
    send_request(r);
  endtask

  task automatic op_only(input logic [1:0] op);
    request_t r;
    r = noise_request();
    r.op = op;
    send_request(r);
  endtask

  task automatic random_leaf_write();
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    node_write(a[8:0], a[17:9], a[26:18], 1'b1, b[7:0]);
  endtask

  function automatic logic [NODE_W-1:0] fresh_node();
    logic [31:0] a;
    do begin
      a = $urandom_range(TREE_NODES_DEF - 1, 1);
    end while (node_taken[a[NODE_W-1:0]]);
    node_taken[a[NODE_W-1:0]] = 1'b1;
    return a[NODE_W-1:0];
  endfunction

  // Bottom-up load, so every inner node written only points at written nodes.
  task automatic load_code_tree(input int leaves, input bit chain);
    logic [NODE_W-1:0] pool [$];
    logic [NODE_W-1:0] lo;
    logic [NODE_W-1:0] hi;
    logic [NODE_W-1:0] idx;
    logic [31:0]       a;
    int                pick;
    foreach (node_taken[i]) node_taken[i] = 1'b0;
    node_taken[0] = 1'b1;
    if (leaves < 2) begin
      a = $urandom;
      node_write('0, a[8:0], a[17:9], 1'b1, a[25:18]);
      return;
    end
    for (int n = 0; n < leaves; n++) begin
      a   = $urandom;
      idx = fresh_node();
      node_write(idx, a[8:0], a[17:9], 1'b1, a[25:18]);
      pool.push_back(idx);
    end
    while (pool.size() > 1) begin
      if (chain) begin
        lo = pool.pop_back();
        hi = pool.pop_front();
      end else begin
        pick = $urandom_range(pool.size() - 1);
        lo   = pool[pick];
        pool.delete(pick);
        pick = $urandom_range(pool.size() - 1);
        hi   = pool[pick];
        pool.delete(pick);
      end
      idx = (pool.size() == 0) ? '0 : fresh_node();
      a   = $urandom;
      if (a[31]) node_write(idx, hi, lo, 1'b0, a[7:0]);
      else       node_write(idx, lo, hi, 1'b0, a[7:0]);
      pool.push_back(idx);
    end
  endtask

  function automatic int pick_leaves();
    return ($urandom_range(9) == 0) ? 1 : int'($urandom_range(12, 2));
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    logic [31:0] a;
    a = $urandom;
    case ($urandom_range(15))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return a;
      default: return {26'd0, a[5:0]} + 32'd2;
    endcase
  endfunction

  // Only with the block idle: every symbol in, then the byte latency on top.
  task automatic set_symbol_count(input logic [CNT_W-1:0] v);
    in_valid_i <= 1'b0;
    while (predictor.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    predictor.set_frame_count(v);
  endtask

  initial begin
    int          roll;
    int          phase_end;
    logic [31:0] a;
    predictor     = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    op_i          = '0;
    node_index_i  = '0;
    left_child_i  = '0;
    right_child_i = '0;
    is_leaf_i     = 1'b0;
    leaf_symbol_i = '0;
    data_byte_i   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // count at zero: bytes ignored, unused op ignored
    set_symbol_count('0);
    byte_in(8'hFF);
    op_only(OP_UNUSED);
    op_only(OP_START);
    byte_in(8'h00);
    node_write('0, 9'h1FF, 9'h1FF, 1'b1, 8'hFF);

    // leaf at the root, then a small tree with carry-over between bytes
    set_symbol_count('1);
    op_only(OP_START);
    byte_in(8'hA5);
    node_write(9'h1FF, 9'h000, 9'h000, 1'b1, 8'h00);
    node_write(9'd2, 9'h155, 9'h0AA, 1'b1, 8'h5A);
    node_write(9'd3, 9'd2, 9'h1FF, 1'b0, 8'hFF);
    node_write('0, 9'h1FF, 9'd3, 1'b0, 8'h00);
    byte_in(8'h00);
    byte_in(8'hFF);
    byte_in(8'hB3);
    byte_in(8'h01);
    byte_in(8'h40);

    // frame ends partway through a byte
    set_symbol_count(32'd3);
    op_only(OP_START);
    byte_in(8'h00);
    byte_in(8'hFF);
    set_symbol_count(32'd1);
    op_only(OP_START);
    byte_in(8'h80);
    byte_in(8'h00);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          in_idle_pct  = 14;
          out_idle_pct = 68;
        end
        1: begin
          in_idle_pct  = 68;
          out_idle_pct = 14;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        set_symbol_count(pick_count());
        if (mode == 2 && ph == 1) hold_left = HOLD_CYCLES;
        phase_end = requests_sent + 36;
        if (ph == 0 || $urandom_range(1) == 1) load_code_tree(pick_leaves(), $urandom_range(3) == 0);
        op_only(OP_START);
        while (requests_sent < phase_end) begin
          roll = $urandom_range(99);
          if (roll < 72) begin
            if (predictor.left_to_emit == 0 && $urandom_range(3) != 0) begin
              op_only(OP_START);
            end else begin
              a = $urandom;
              byte_in(a[7:0]);
            end
          end else if (roll < 80) begin
            op_only(OP_START);
          end else if (roll < 85) begin
            op_only(OP_UNUSED);
          end else if (roll < 92) begin
            random_leaf_write();
          end else begin
            load_code_tree(pick_leaves(), $urandom_range(3) == 0);
          end
        end
      end
    end

    in_valid_i <= 1'b0;
    while (predictor.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (predictor.mismatches == 0 && predictor.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
